// ===== rtl/core/aep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aep_pkg;

  // Characters with a meaning of their own in the header grammar.
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrSemi  = 8'h3B;
  localparam logic [7:0] ChrEq    = 8'h3D;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrLowQ  = 8'h71;
  localparam logic [7:0] ChrStar  = 8'h2A;

  // Token indexes into the per-token bit vectors.
  localparam int unsigned TokZstd = 0;
  localparam int unsigned TokGzip = 1;
  localparam int unsigned TokStar = 2;
  localparam int unsigned NumTok  = 3;

  typedef enum logic [1:0] {
    SEC_NAME  = 2'd0,
    SEC_PNAME = 2'd1,
    SEC_QVAL  = 2'd2,
    SEC_SKIP  = 2'd3
  } aep_section_e;

  typedef enum logic [2:0] {
    PN_LEAD  = 3'd0,
    PN_Q     = 3'd1,
    PN_Q_SP  = 3'd2,
    PN_OTHER = 3'd3
  } aep_pname_e;

  typedef struct packed {
    aep_section_e        section;
    logic [2:0]          name_position;
    logic                name_trailing_space;
    logic [NumTok-1:0]   name_mismatch;
    aep_pname_e          param_name_state;
    logic                q_decided;
    logic [1:0]          qvalue_flags;
    logic                entry_ok;
    logic [NumTok-1:0]   token_found;
    logic [NumTok-1:0]   token_accept;
  } aep_state_t;

  typedef struct packed {
    logic zstd_ok;
    logic gzip_ok;
    logic zstd_named;
    logic gzip_named;
    logic star_named;
  } aep_result_t;

  localparam aep_state_t StateReset = '{
    section:             SEC_NAME,
    name_position:       3'd0,
    name_trailing_space: 1'b0,
    name_mismatch:       '0,
    param_name_state:    PN_LEAD,
    q_decided:           1'b0,
    qvalue_flags:        2'b00,
    entry_ok:            1'b1,
    token_found:         '0,
    token_accept:        '0
  };

endpackage

`default_nettype wire

// ===== rtl/core/aep_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;

  modport source (output valid, output char_byte, output last, input ready);
  modport sink (input valid, input char_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aep_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface aep_out_if;
  logic valid;
  logic ready;
  logic zstd_ok;
  logic gzip_ok;
  logic zstd_named;
  logic gzip_named;
  logic star_named;

  modport source (
    output valid, output zstd_ok, output gzip_ok, output zstd_named,
    output gzip_named, output star_named, input ready
  );
  modport sink (
    input valid, input zstd_ok, input gzip_ok, input zstd_named,
    input gzip_named, input star_named, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/aep_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic for one header byte, plus the verdict on the final byte.
module aep_step import aep_pkg::*; (
  input  aep_state_t  state_i,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output aep_state_t  state_o,
  output aep_result_t result_o
);

  function automatic logic [7:0] tok_chr(input int unsigned t, input logic [1:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (t)
      TokZstd: begin
        case (pos)
          2'd0:    r = 8'h7A;
          2'd1:    r = 8'h73;
          2'd2:    r = 8'h74;
          default: r = 8'h64;
        endcase
      end
      TokGzip: begin
        case (pos)
          2'd0:    r = 8'h67;
          2'd1:    r = 8'h7A;
          2'd2:    r = 8'h69;
          default: r = 8'h70;
        endcase
      end
      default: r = (pos == 2'd0) ? ChrStar : 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] tok_len(input int unsigned t);
    logic [2:0] r;
    case (t)
      TokStar: r = 3'd1;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic aep_state_t finish_name(input aep_state_t s);
    aep_state_t        r;
    logic [NumTok-1:0] m;
    r = s;
    m = '0;
    for (int unsigned t = 0; t < NumTok; t++) begin
      m[t] = !s.name_mismatch[t] && (s.name_position == tok_len(t));
    end
    r.name_mismatch = ~m;
    return r;
  endfunction

  function automatic aep_state_t finish_q(input aep_state_t s);
    aep_state_t r;
    r = s;
    r.entry_ok  = (s.qvalue_flags != 2'b01);
    r.q_decided = 1'b1;
    return r;
  endfunction

  function automatic aep_state_t end_entry(input aep_state_t s);
    aep_state_t        r;
    logic [NumTok-1:0] m;
    r = s;
    if (s.section == SEC_NAME) r = finish_name(s);
    else if (s.section == SEC_QVAL) r = finish_q(s);
    m = ~r.name_mismatch & ~r.token_found;
    r.token_found = r.token_found | m;
    if (r.entry_ok) r.token_accept = r.token_accept | m;
    else r.token_accept = r.token_accept & ~m;
    // Back to a fresh entry; the per-token results carry on.
    r.section             = SEC_NAME;
    r.name_position       = 3'd0;
    r.name_trailing_space = 1'b0;
    r.name_mismatch       = '0;
    r.param_name_state    = PN_LEAD;
    r.q_decided           = 1'b0;
    r.qvalue_flags        = 2'b00;
    r.entry_ok            = 1'b1;
    return r;
  endfunction

  aep_state_t s;
  aep_state_t e;
  logic [7:0] f;
  logic       ws;
  logic       is_q;

  assign f  = fold(char_byte_i);
  assign ws = (char_byte_i == ChrSpace) || (char_byte_i == ChrTab);

  always_comb begin
    s    = state_i;
    is_q = 1'b0;
    if (char_byte_i == ChrComma) begin
      s = end_entry(state_i);
    end else if (char_byte_i == ChrSemi) begin
      if (state_i.section == SEC_NAME) s = finish_name(state_i);
      else if (state_i.section == SEC_QVAL) s = finish_q(state_i);
      s.section          = SEC_PNAME;
      s.param_name_state = PN_LEAD;
    end else begin
      case (state_i.section)
        SEC_NAME: begin
          if (ws) begin
            if (state_i.name_position != 3'd0) s.name_trailing_space = 1'b1;
          end else begin
            if (state_i.name_trailing_space) begin
              s.name_mismatch = '1;
            end else begin
              for (int unsigned t = 0; t < NumTok; t++) begin
                if (state_i.name_position >= tok_len(t) ||
                    f != tok_chr(t, state_i.name_position[1:0])) begin
                  s.name_mismatch[t] = 1'b1;
                end
              end
            end
            if (state_i.name_position != 3'd7) begin
              s.name_position = state_i.name_position + 3'd1;
            end
          end
        end
        SEC_PNAME: begin
          if (char_byte_i == ChrEq) begin
            is_q = (state_i.param_name_state == PN_Q) ||
                   (state_i.param_name_state == PN_Q_SP);
            s.section      = (is_q && !state_i.q_decided) ? SEC_QVAL : SEC_SKIP;
            s.qvalue_flags = 2'b00;
          end else if (ws) begin
            if (state_i.param_name_state == PN_Q) s.param_name_state = PN_Q_SP;
          end else if (state_i.param_name_state == PN_LEAD && f == ChrLowQ) begin
            s.param_name_state = PN_Q;
          end else begin
            s.param_name_state = PN_OTHER;
          end
        end
        SEC_QVAL: begin
          if (!ws && char_byte_i != ChrDot) begin
            if (char_byte_i == ChrZero) s.qvalue_flags[0] = 1'b1;
            else s.qvalue_flags[1] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Closing pass for the final byte of the header.
  assign e = end_entry(s);

  always_comb begin
    result_o.zstd_ok = e.token_found[TokZstd] ? e.token_accept[TokZstd] :
                       (e.token_found[TokStar] & e.token_accept[TokStar]);
    result_o.gzip_ok = e.token_found[TokGzip] ? e.token_accept[TokGzip] :
                       (e.token_found[TokStar] & e.token_accept[TokStar]);
    result_o.zstd_named = e.token_found[TokZstd];
    result_o.gzip_named = e.token_found[TokGzip];
    result_o.star_named = e.token_found[TokStar];
  end

  assign state_o = last_i ? StateReset : s;

endmodule

`default_nettype wire

// ===== rtl/core/aep_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds one verdict until the receiver takes it.
module aep_out_reg import aep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  aep_result_t result_i,
  output logic        free_o,
  aep_out_if.source   out_o
);

  logic        valid_q;
  logic        valid_d;
  aep_result_t result_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.zstd_ok    = result_q.zstd_ok;
  assign out_o.gzip_ok    = result_q.gzip_ok;
  assign out_o.zstd_named = result_q.zstd_named;
  assign out_o.gzip_named = result_q.gzip_named;
  assign out_o.star_named = result_q.star_named;

endmodule

`default_nettype wire

// ===== rtl/core/accept_encoding_parser.sv =====
// Accept-Encoding parser: reads an HTTP Accept-Encoding header value one
// byte per beat on in_i (char_byte, with last marking the final byte) and
// gives one verdict beat on out_o for each header: whether zstd and gzip
// are acceptable and which of zstd, gzip and the wildcard were named.
// An empty header is sent as a single comma with last set.
// Throughput is one byte per cycle, except while a final byte is held
// back as below; a new header may start on the beat after the last byte
// of the previous one. Each byte is captured in an input register and the
// parser state is updated from it by a single layer of per-byte logic;
// the verdict is written to an output register at the same time, and
// out_o is driven from that register. After reset no beat is pending and
// the parser waits at the start of an entry. If the receiver stalls, the
// verdict stays in the output register; ordinary bytes still flow through,
// and only a further final byte is held in the input register until the
// verdict has been taken.
`timescale 1ns / 1ps
`default_nettype none

module accept_encoding_parser import aep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  aep_in_if.sink     in_i,
  aep_out_if.source  out_o
);

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state across bytes of one header.
  aep_state_t  state_q;
  aep_state_t  state_d;
  aep_result_t result;

  logic out_free;
  logic advance;
  logic load;

  // The held byte moves on unless it is a final byte and the verdict slot
  // is still occupied.
  assign advance    = in_valid_q && (!in_last_q || out_free);
  assign load       = advance && in_last_q;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.char_byte;
      in_last_q <= in_i.last;
    end
  end

  aep_step u_step (
    .state_i     (state_q),
    .char_byte_i (in_byte_q),
    .last_i      (in_last_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  aep_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire
